[design/lpht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants of the linear probe hash table
// Operation codes, result status codes, slot states, field widths and the reset limit.
// ----------------------------------------------------------------------------
package lpht_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_ERASE  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DUP  = 2'd1,
    STATUS_MISS = 2'd2,
    STATUS_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_LIVE    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_st_t;

  localparam int          LIMIT_BITS       = 9;
  localparam int          FIELD_BITS       = 32;
  localparam int          INDEX_BITS       = 8;
  localparam logic [8:0]  LOAD_LIMIT_RESET = 9'd180;

endpackage

`default_nettype wire

[design/lpht_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_req_if: request channel of the linear probe hash table
// Valid/ready channel carrying opcode, key and entry value.
// ----------------------------------------------------------------------------
interface lpht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] key;
  logic [31:0] entry_value;

  modport source (output valid, output opcode, output key, output entry_value, input ready);
  modport sink (input valid, input opcode, input key, input entry_value, output ready);
endinterface

`default_nettype wire

[design/lpht_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_rsp_if: response channel of the linear probe hash table
// Valid/ready channel carrying status, found value and slot index.
// ----------------------------------------------------------------------------
interface lpht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_value;
  logic [7:0]  slot_index;

  modport source (output valid, output status, output found_value, output slot_index,
                  input ready);
  modport sink (input valid, input status, input found_value, input slot_index,
                output ready);
endinterface

`default_nettype wire

[design/linear_probe_hash_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing key/value table, linear probing
// Usage:
//   req carries one request (insert, find or erase) per handshake; rsp
//   returns exactly one response per request, in order. cfg_we/cfg_wdata
//   write load_limit; write it only while no request is in flight.
//   Steps: take the key, hash it (when SLOTS is not a power of two: a
//   reciprocal multiply, then a multiply and subtract), read and check each
//   slot probed through the single slot memory port, post the response. An
//   unused opcode or an insert at the limit skips hash and probe. A probe run
//   ends at a match, an empty slot (insert: any slot not live) or one full lap.
//   One request is worked at a time; req.ready is high only when idle.
//   The response sits in an output register, so the next request is taken
//   while it waits; if rsp is stalled when the next response is ready, the
//   block holds that response until rsp.ready.
//   Reset: a clearing pass marks every slot empty, one slot per cycle;
//   req.ready stays low meanwhile. load_limit resets to 180
//   and the entry count to zero. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int SLOTS      = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  lpht_req_if.sink                                req,
  lpht_rsp_if.source                              rsp,
  input  wire logic                               cfg_we,
  input  wire logic [lpht_pkg::LIMIT_BITS-1:0]    cfg_wdata
);

  localparam int  AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int  CW   = $clog2(SLOTS + 1);
  localparam int  MW   = (CW > lpht_pkg::LIMIT_BITS) ? CW : lpht_pkg::LIMIT_BITS;
  localparam int  KW   = (KEY_BITS < lpht_pkg::FIELD_BITS) ? KEY_BITS : lpht_pkg::FIELD_BITS;
  localparam int  VW   = (VALUE_BITS < lpht_pkg::FIELD_BITS) ? VALUE_BITS
                                                             : lpht_pkg::FIELD_BITS;
  localparam bit  POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
  localparam logic [32:0]   RECIP = 33'(((64'd1 << (32 + AW)) + 64'(SLOTS) - 64'd1)
                                        / 64'(SLOTS));

  typedef struct packed {
    lpht_pkg::slot_st_t st;
    logic [KW-1:0]      k;
    logic [VW-1:0]      v;
  } word_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_RESP
  } state_t;

  state_t                          state;
  logic [AW-1:0]                   s;
  logic [AW-1:0]                   cnt;
  logic                            hash_step;
  logic [64:0]                     prod;
  logic [1:0]                      op;
  logic [KW-1:0]                   key_r;
  logic [VW-1:0]                   val_r;
  lpht_pkg::status_t               status_r;
  logic [VW-1:0]                   fval_r;
  logic [AW-1:0]                   where_r;
  logic [CW-1:0]                   entry_count;
  logic [lpht_pkg::LIMIT_BITS-1:0] load_limit;

  logic                            rsp_valid;
  logic [1:0]                      rsp_status;
  logic [31:0]                     rsp_fval;
  logic [7:0]                      rsp_index;

  word_t                           mem [SLOTS];
  word_t                           rdata;
  logic                            mem_we;
  word_t                           mem_wdata;

  logic [31:0]                     key_ext;
  logic [31:0]                     quot;
  logic [31:0]                     rem_full;
  logic [AW-1:0]                   home;
  logic [AW-1:0]                   s_next;
  logic                            at_limit;
  logic                            hit;
  logic [31:0]                     where_ext;

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = rsp_valid;
  assign rsp.status  = rsp_status;
  assign rsp.found_value = rsp_fval;
  assign rsp.slot_index  = rsp_index;

  assign key_ext   = 32'(key_r);
  assign quot      = 32'(prod >> (32 + AW));
  assign rem_full  = key_ext - quot * 32'(SLOTS);
  assign home      = POW2 ? key_ext[AW-1:0] : rem_full[AW-1:0];
  assign s_next    = (s == LAST) ? '0 : s + 1'b1;
  assign at_limit  = (MW'(entry_count) >= MW'(load_limit));
  assign hit       = (rdata.st == lpht_pkg::SLOT_LIVE) && (rdata.k == key_r);
  assign where_ext = 32'(where_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rdata;
    if (state == S_CLEAR) begin
      mem_we       = 1'b1;
      mem_wdata.st = lpht_pkg::SLOT_EMPTY;
      mem_wdata.k  = '0;
      mem_wdata.v  = '0;
    end else if (state == S_CHECK) begin
      if (op == lpht_pkg::OP_INSERT && rdata.st != lpht_pkg::SLOT_LIVE) begin
        mem_we       = 1'b1;
        mem_wdata.st = lpht_pkg::SLOT_LIVE;
        mem_wdata.k  = key_r;
        mem_wdata.v  = val_r;
      end else if (op == lpht_pkg::OP_ERASE && hit) begin
        mem_we       = 1'b1;
        mem_wdata.st = lpht_pkg::SLOT_DELETED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[s] <= mem_wdata;
    end
    rdata <= mem[s];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= lpht_pkg::LOAD_LIMIT_RESET;
    end else if (cfg_we) begin
      load_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      s           <= '0;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      rsp_valid <= (state == S_RESP && (!rsp_valid || rsp.ready)) ||
                   (rsp_valid && !rsp.ready);
      unique case (state)
        S_CLEAR: begin
          s <= s_next;
          if (s == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op        <= req.opcode;
            key_r     <= req.key[KW-1:0];
            val_r     <= req.entry_value[VW-1:0];
            hash_step <= 1'b0;
            cnt       <= '0;
            fval_r    <= '0;
            where_r   <= '0;
            status_r  <= lpht_pkg::STATUS_MISS;
            priority if (req.opcode == lpht_pkg::OP_INSERT && at_limit) begin
              status_r <= lpht_pkg::STATUS_FULL;
              state    <= S_RESP;
            end else if (req.opcode == lpht_pkg::OP_INSERT ||
                         req.opcode == lpht_pkg::OP_FIND ||
                         req.opcode == lpht_pkg::OP_ERASE) begin
              state <= S_HASH;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_HASH: begin
          hash_step <= 1'b1;
          prod      <= 65'(key_ext) * 65'(RECIP);
          if (POW2 || hash_step) begin
            s     <= home;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          priority if (op == lpht_pkg::OP_INSERT && rdata.st != lpht_pkg::SLOT_LIVE) begin
            entry_count <= entry_count + 1'b1;
            where_r     <= s;
            status_r    <= lpht_pkg::STATUS_OK;
            state       <= S_RESP;
          end else if (op == lpht_pkg::OP_INSERT && rdata.k == key_r) begin
            status_r <= lpht_pkg::STATUS_DUP;
            state    <= S_RESP;
          end else if (op != lpht_pkg::OP_INSERT && rdata.st == lpht_pkg::SLOT_EMPTY) begin
            status_r <= lpht_pkg::STATUS_MISS;
            state    <= S_RESP;
          end else if (op != lpht_pkg::OP_INSERT && hit) begin
            where_r  <= s;
            status_r <= lpht_pkg::STATUS_OK;
            if (op == lpht_pkg::OP_FIND) begin
              fval_r <= rdata.v;
            end else if (entry_count != '0) begin
              entry_count <= entry_count - 1'b1;
            end
            state <= S_RESP;
          end else if (cnt == LAST) begin
            status_r <= (op == lpht_pkg::OP_INSERT) ? lpht_pkg::STATUS_FULL
                                                    : lpht_pkg::STATUS_MISS;
            state    <= S_RESP;
          end else begin
            cnt   <= cnt + 1'b1;
            s     <= s_next;
            state <= S_READ;
          end
        end
        S_RESP: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_status <= status_r;
            rsp_fval   <= 32'(fval_r);
            rsp_index  <= where_ext[lpht_pkg::INDEX_BITS-1:0];
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/lpht_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_checker: port-level checks of the linear probe hash table
// Watches the request and response channels and flags protocol or result
// inconsistencies.
// ----------------------------------------------------------------------------
module lpht_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  rsp_status,
  input wire logic [31:0] rsp_found_value,
  input wire logic [7:0]  rsp_slot_index
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_found_value) && $stable(rsp_slot_index))
    else $error("response changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != lpht_pkg::STATUS_OK |-> rsp_slot_index == 8'd0)
    else $error("slot index set on failed request");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != lpht_pkg::STATUS_OK |-> rsp_found_value == 32'd0)
    else $error("found value set on failed request");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_found_value (rsp.found_value),
  .rsp_slot_index  (rsp.slot_index)
);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the linear probe hash table
// Drives insert, find, erase and unused-opcode requests through the valid/ready request
// channel and checks every response, in order, against a scoreboard that
// keeps its own copy of the slot array, the entry count and load_limit.
// Covers a directed opening, random phases at several load limits with
// random bursts and receiver stalls, and a final pass that fills the table.
// ----------------------------------------------------------------------------

localparam int unsigned SLOT_COUNT = 256;
localparam logic [1:0]  OP_UNUSED  = 2'd3;

typedef struct packed {
  lpht_pkg::status_t status;
  logic [31:0]       found_value;
  logic [7:0]        slot_index;
} hash_rsp_t;

class hash_scoreboard;
  lpht_pkg::slot_st_t slot_state [SLOT_COUNT];
  logic [31:0] slot_key [SLOT_COUNT];
  logic [31:0] slot_value [SLOT_COUNT];
  int unsigned entry_count;
  logic [8:0]  load_limit;
  hash_rsp_t   expected_rsp [$];
  int unsigned errors;

  function new();
    for (int s = 0; s < SLOT_COUNT; s++) begin
      slot_state[s] = lpht_pkg::SLOT_EMPTY;
      slot_key[s]   = '0;
      slot_value[s] = '0;
    end
    entry_count = 0;
    load_limit  = lpht_pkg::LOAD_LIMIT_RESET;
    errors      = 0;
  endfunction

  function bit find_live(logic [31:0] key, output int unsigned where);
    int unsigned s;
    int unsigned n;
    bit          hit;
    bit          stop;
    s     = key % SLOT_COUNT;
    hit   = 1'b0;
    stop  = 1'b0;
    where = 0;
    for (n = 0; n < SLOT_COUNT && !stop; n++) begin
      if (slot_state[s] == lpht_pkg::SLOT_EMPTY) begin
        stop = 1'b1;
      end else if (slot_state[s] == lpht_pkg::SLOT_LIVE && slot_key[s] == key) begin
        hit   = 1'b1;
        stop  = 1'b1;
        where = s;
      end else begin
        s = (s + 1) % SLOT_COUNT;
      end
    end
    return hit;
  endfunction

  function hash_rsp_t compute_response(logic [1:0] op, logic [31:0] key,
                                       logic [31:0] value);
    hash_rsp_t   r;
    int unsigned s;
    int unsigned n;
    bit          stop;
    r.status      = lpht_pkg::STATUS_MISS;
    r.found_value = '0;
    r.slot_index  = '0;
    case (op)
      lpht_pkg::OP_INSERT: begin
        r.status = lpht_pkg::STATUS_FULL;
        if (entry_count < load_limit) begin
          s    = key % SLOT_COUNT;
          stop = 1'b0;
          for (n = 0; n < SLOT_COUNT && !stop; n++) begin
            if (slot_state[s] != lpht_pkg::SLOT_LIVE) begin
              slot_state[s] = lpht_pkg::SLOT_LIVE;
              slot_key[s]   = key;
              slot_value[s] = value;
              entry_count++;
              r.status      = lpht_pkg::STATUS_OK;
              r.slot_index  = 8'(s);
              stop          = 1'b1;
            end else if (slot_key[s] == key) begin
              r.status = lpht_pkg::STATUS_DUP;
              stop     = 1'b1;
            end else begin
              s = (s + 1) % SLOT_COUNT;
            end
          end
        end
      end
      lpht_pkg::OP_FIND: begin
        if (find_live(key, s)) begin
          r.status      = lpht_pkg::STATUS_OK;
          r.found_value = slot_value[s];
          r.slot_index  = 8'(s);
        end
      end
      lpht_pkg::OP_ERASE: begin
        if (find_live(key, s)) begin
          slot_state[s] = lpht_pkg::SLOT_DELETED;
          if (entry_count > 0) entry_count--;
          r.status     = lpht_pkg::STATUS_OK;
          r.slot_index = 8'(s);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function void note_request(logic [1:0] op, logic [31:0] key, logic [31:0] value);
    expected_rsp = {expected_rsp, compute_response(op, key, value)};
  endfunction

  function void check_response(logic [1:0] status, logic [31:0] found_value,
                               logic [7:0] slot_index);
    hash_rsp_t want;
    if (expected_rsp.size() == 0) begin
      $error("response with no request outstanding: status %0d", status);
      errors++;
      return;
    end
    want = expected_rsp.pop_front();
    if (status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, status);
      errors++;
    end
    if (found_value !== want.found_value) begin
      $error("found_value: expected %0h, actual %0h", want.found_value, found_value);
      errors++;
    end
    if (slot_index !== want.slot_index) begin
      $error("slot_index: expected %0d, actual %0d", want.slot_index, slot_index);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int          POOL_SIZE   = 40;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [8:0]  cfg_wdata;
  int          hold_cycles = 0;
  int unsigned cycle_count;
  logic [31:0] key_pool [POOL_SIZE];
  hash_scoreboard sb;

  lpht_req_if req_ch ();
  lpht_rsp_if rsp_ch ();

  linear_probe_hash_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: errors");
    $finish;
  end

  // receiver: long hold when asked, else a rotating stall pattern
  initial begin
    logic [15:0] stall_mask;
    int unsigned tick;
    rsp_ch.ready <= 1'b0;
    stall_mask = 16'hFFFF;
    tick       = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        if (tick % 64 == 0) begin
          stall_mask = $urandom;
          if ($urandom_range(0, 2) == 0) stall_mask = 16'hFFFF;
          stall_mask = stall_mask | 16'h0101;
        end
        rsp_ch.ready <= stall_mask[0];
        stall_mask = {stall_mask[0], stall_mask[15:1]};
        tick++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_response(rsp_ch.status, rsp_ch.found_value, rsp_ch.slot_index);
  end

  task automatic send_req(input logic [1:0] op, input logic [31:0] key,
                          input logic [31:0] value);
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.key         <= key;
    req_ch.entry_value <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(op, key, value);
  endtask

  task automatic idle_for(input int cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [8:0] limit);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.load_limit = limit;
  endtask

  task automatic send_random();
    logic [1:0]  op;
    logic [31:0] key;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      op = lpht_pkg::OP_INSERT;
    else if (pick < 70) op = lpht_pkg::OP_FIND;
    else if (pick < 96) op = lpht_pkg::OP_ERASE;
    else                op = OP_UNUSED;
    if ($urandom_range(0, 9) == 0) key = $urandom;
    else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    send_req(op, key, $urandom);
  endtask

  task automatic run_random(input int count, input bit hold_off);
    int burst;
    int gap;
    if (hold_off) begin
      hold_cycles = 400;
      repeat (40) send_random();
      count -= 40;
    end
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && count > 0) begin
        send_random();
        burst--;
        count--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) idle_for(gap);
    end
  endtask

  task automatic erase_all_live();
    logic [31:0] live_keys [$];
    wait_drained();
    for (int s = 0; s < SLOT_COUNT; s++)
      if (sb.slot_state[s] == lpht_pkg::SLOT_LIVE) live_keys = {live_keys, sb.slot_key[s]};
    foreach (live_keys[i]) send_req(lpht_pkg::OP_ERASE, live_keys[i], $urandom);
  endtask

  task automatic fill_table();
    logic [31:0] key;
    write_limit(9'd511);
    erase_all_live();
    for (int s = 0; s < SLOT_COUNT; s++) begin
      key      = $urandom;
      key[7:0] = 8'(s);
      send_req(lpht_pkg::OP_INSERT, key, $urandom);
    end
    send_req(lpht_pkg::OP_INSERT, $urandom, $urandom);
    send_req(lpht_pkg::OP_INSERT, sb.slot_key[17], $urandom);
    send_req(lpht_pkg::OP_FIND, $urandom, $urandom);
    send_req(lpht_pkg::OP_FIND, sb.slot_key[200], $urandom);
    write_limit(9'd256);
    send_req(lpht_pkg::OP_INSERT, $urandom, $urandom);
    erase_all_live();
    send_req(lpht_pkg::OP_FIND, $urandom, $urandom);
    send_req(lpht_pkg::OP_ERASE, $urandom, $urandom);
    send_req(lpht_pkg::OP_INSERT, $urandom, $urandom);
  endtask

  task automatic run_directed();
    // home slot 5 collisions, then wrap from slot 255 to slot 0
    send_req(lpht_pkg::OP_INSERT, 32'h1234_5605, 32'h0000_0001);
    send_req(lpht_pkg::OP_INSERT, 32'hABCD_EF05, 32'h0000_0002);
    send_req(lpht_pkg::OP_INSERT, 32'h1234_5605, 32'h0000_0009);
    send_req(lpht_pkg::OP_FIND,   32'h1234_5605, 32'h0);
    send_req(lpht_pkg::OP_FIND,   32'hABCD_EF05, 32'h0);
    send_req(lpht_pkg::OP_FIND,   32'h0000_0105, 32'h0);
    send_req(lpht_pkg::OP_ERASE,  32'h1234_5605, 32'h0);
    send_req(lpht_pkg::OP_FIND,   32'hABCD_EF05, 32'h0);
    send_req(lpht_pkg::OP_FIND,   32'h1234_5605, 32'h0);
    send_req(lpht_pkg::OP_INSERT, 32'h0000_0105, 32'h5A5A_A5A5);
    send_req(lpht_pkg::OP_INSERT, 32'hABCD_EF05, 32'h0000_0003);
    send_req(lpht_pkg::OP_INSERT, 32'h5555_55FF, 32'hDEAD_BEEF);
    send_req(lpht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(lpht_pkg::OP_FIND,   32'hFFFF_FFFF, 32'h0);
    send_req(lpht_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_req(lpht_pkg::OP_FIND,   32'h0000_0000, 32'hFFFF_FFFF);
    send_req(lpht_pkg::OP_ERASE,  32'h0BAD_F00D, 32'h0);
    send_req(OP_UNUSED,           32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(lpht_pkg::OP_ERASE,  32'hFFFF_FFFF, 32'h0);
    send_req(lpht_pkg::OP_FIND,   32'h0000_0000, 32'h0);
    // limit checked before probing, even for a present key
    write_limit(9'd1);
    send_req(lpht_pkg::OP_INSERT, 32'hABCD_EF05, 32'h0000_0004);
    send_req(lpht_pkg::OP_INSERT, 32'h7777_7777, 32'h0000_0005);
    write_limit(9'd0);
    send_req(lpht_pkg::OP_INSERT, 32'h8888_8888, 32'h0000_0006);
    send_req(lpht_pkg::OP_FIND,   32'h5555_55FF, 32'h0);
  endtask

  initial begin
    int phase_limit [6];
    logic [31:0] key;
    sb = new();
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.opcode      <= '0;
    req_ch.key         <= '0;
    req_ch.entry_value <= '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key = $urandom;
      case ($urandom_range(0, 2))
        0:       key[7:0] = 8'(0 + $urandom_range(0, 7));
        1:       key[7:0] = 8'(120 + $urandom_range(0, 7));
        default: key[7:0] = 8'(248 + $urandom_range(0, 7));
      endcase
      key_pool[i] = key;
    end
    phase_limit    = '{180, 8, 256, 511, 1, 3};
    phase_limit[4] = $urandom_range(1, 256);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    foreach (phase_limit[p]) begin
      write_limit(9'(phase_limit[p]));
      run_random(215, p == 0);
    end
    fill_table();

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
